>>> rtl/core/sphere_box_overlap_with_face_core_assert.svh
// ----------------------------------------------------------------------------
// Sphere/box overlap core - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SPHERE_BOX_OVERLAP_WITH_FACE_CORE_ASSERT_SVH
`define SPHERE_BOX_OVERLAP_WITH_FACE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SBO_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SBO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/sbo_pkg.sv
// ----------------------------------------------------------------------------
// sbo_pkg
// Types and constants shared by the sphere/box overlap core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbo_pkg;

  // Q12.12 coordinates; sizes and radius are one bit narrower (unsigned)
  localparam int COORD_BITS = 24;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  // doubled-scale span bounds and distances
  localparam int SPAN_BITS  = COORD_BITS + 2;
  // doubled radius; a near gap is below it and fits the same width
  localparam int R2_BITS    = COORD_BITS;
  localparam int SQ_BITS    = 2 * R2_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;
  // box center minus sphere center
  localparam int DIFF_BITS  = COORD_BITS + 1;

  typedef enum logic [2:0] {
    FACE_NONE  = 3'd0,
    FACE_LEFT  = 3'd1,
    FACE_RIGHT = 3'd2,
    FACE_DOWN  = 3'd3,
    FACE_UP    = 3'd4,
    FACE_FRONT = 3'd5,
    FACE_BACK  = 3'd6
  } face_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sphere_x;
    logic signed [COORD_BITS-1:0] sphere_y;
    logic signed [COORD_BITS-1:0] sphere_z;
    logic        [SIZE_BITS-1:0]  radius;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic signed [COORD_BITS-1:0] box_z;
    logic        [SIZE_BITS-1:0]  extent_x;
    logic        [SIZE_BITS-1:0]  extent_y;
    logic        [SIZE_BITS-1:0]  extent_z;
  } query_t;

  typedef struct packed {
    logic  hit;
    face_t face;
  } result_t;

endpackage

>>> rtl/core/sbo_axis_gap.sv
// ----------------------------------------------------------------------------
// sbo_axis_gap
// Doubled-scale distance from the sphere center to the box span on one axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbo_axis_gap import sbo_pkg::*; (
  input  logic signed [COORD_BITS-1:0] center,
  input  logic signed [COORD_BITS-1:0] box,
  input  logic        [SIZE_BITS-1:0]  size,
  input  logic        [R2_BITS-1:0]    r2x,
  output logic        [R2_BITS-1:0]    gap,
  output logic                         near
);

  logic signed [SPAN_BITS-1:0] s2;
  logic signed [SPAN_BITS-1:0] c2;
  logic signed [SPAN_BITS-1:0] ev;
  logic signed [SPAN_BITS-1:0] lo;
  logic signed [SPAN_BITS-1:0] hi;
  logic        [SPAN_BITS-1:0] span_gap;

  // half size is exact at doubled scale: span = 2*box +- size
  assign s2 = {center[COORD_BITS-1], center, 1'b0};
  assign c2 = {box[COORD_BITS-1], box, 1'b0};
  assign ev = {3'b000, size};
  assign lo = c2 - ev;
  assign hi = c2 + ev;

  // true distance is below 2^SPAN_BITS, so the wrapped difference is exact
  always_comb begin
    if (s2 < lo) begin
      span_gap = unsigned'(lo - s2);
    end else if (s2 > hi) begin
      span_gap = unsigned'(s2 - hi);
    end else begin
      span_gap = '0;
    end
  end

  assign near = span_gap < {2'b00, r2x};
  assign gap  = span_gap[R2_BITS-1:0];

endmodule

>>> rtl/core/sbo_face_pick.sv
// ----------------------------------------------------------------------------
// sbo_face_pick
// Face from the dominant axis of box center minus sphere center.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbo_face_pick import sbo_pkg::*; (
  input  query_t q,
  output face_t  face
);

  logic signed [DIFF_BITS-1:0] dx;
  logic signed [DIFF_BITS-1:0] dy;
  logic signed [DIFF_BITS-1:0] dz;
  logic        [DIFF_BITS-1:0] ax;
  logic        [DIFF_BITS-1:0] ay;
  logic        [DIFF_BITS-1:0] az;

  assign dx = {q.box_x[COORD_BITS-1], q.box_x} - {q.sphere_x[COORD_BITS-1], q.sphere_x};
  assign dy = {q.box_y[COORD_BITS-1], q.box_y} - {q.sphere_y[COORD_BITS-1], q.sphere_y};
  assign dz = {q.box_z[COORD_BITS-1], q.box_z} - {q.sphere_z[COORD_BITS-1], q.sphere_z};

  // negating the most negative value still reads right as unsigned
  assign ax = dx[DIFF_BITS-1] ? unsigned'(-dx) : unsigned'(dx);
  assign ay = dy[DIFF_BITS-1] ? unsigned'(-dy) : unsigned'(dy);
  assign az = dz[DIFF_BITS-1] ? unsigned'(-dz) : unsigned'(dz);

  // ties: x over y, z over both
  always_comb begin
    if ((ax >= ay) && (az < ax)) begin
      face = dx[DIFF_BITS-1] ? FACE_RIGHT : FACE_LEFT;
    end else if ((ax < ay) && (az < ay)) begin
      face = dy[DIFF_BITS-1] ? FACE_UP : FACE_DOWN;
    end else begin
      face = dz[DIFF_BITS-1] ? FACE_BACK : FACE_FRONT;
    end
  end

endmodule

>>> rtl/core/sphere_box_overlap_with_face_core.sv
// ----------------------------------------------------------------------------
// sphere_box_overlap_with_face_core
// Sphere versus axis-aligned box overlap test with hit face.
// ----------------------------------------------------------------------------
// Takes one sphere/box query per clock while the result side keeps accepting
// results, and returns one result per query, in order. A query passes four
// registers: the input register (loaded at the transfer), the per-axis gap and
// face stage, the squaring stage (three 24x24 multipliers plus the radius
// square), then the sum-and-compare result register, which drives
// result_valid. Every stage advances when the one after it is empty or moving,
// so a stall on the result side holds up to four queries before query_ready
// drops. All lengths are handled at doubled scale, so the test is exact; face
// is FACE_NONE (0) on a miss.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sphere_box_overlap_with_face_core_assert.svh"

module sphere_box_overlap_with_face_core import sbo_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    query_valid,
  output logic    query_ready,
  input  query_t  query,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  // stage enables: a stage loads when it is empty or its contents move on
  logic en_out;
  logic en_b;
  logic en_a;
  logic en_q;

  // input register
  logic   q_valid;
  query_t q_data;

  // gap stage
  logic                 a_valid;
  logic [R2_BITS-1:0]   a_gap [3];
  logic                 a_near;
  logic [R2_BITS-1:0]   a_r2x;
  face_t                a_face;

  // squaring stage
  logic                 b_valid;
  logic [SQ_BITS-1:0]   b_sq [3];
  logic [SQ_BITS-1:0]   b_rsq;
  logic                 b_near;
  face_t                b_face;

  // combinational
  logic [R2_BITS-1:0]   r2x;
  logic [R2_BITS-1:0]   gap [3];
  logic [2:0]           near;
  face_t                face;
  logic [SUM_BITS-1:0]  sum;
  logic                 hit;

  assign en_out      = !result_valid || result_ready;
  assign en_b        = !b_valid || en_out;
  assign en_a        = !a_valid || en_b;
  assign en_q        = !q_valid || en_a;
  assign query_ready = en_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid      <= 1'b0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en_q)   q_valid      <= query_valid;
      if (en_a)   a_valid      <= q_valid;
      if (en_b)   b_valid      <= a_valid;
      if (en_out) result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_q) q_data <= query;
  end

  // ---- gap and face ----
  assign r2x = {q_data.radius, 1'b0};

  sbo_axis_gap u_gap_x (
    .center (q_data.sphere_x),
    .box    (q_data.box_x),
    .size   (q_data.extent_x),
    .r2x    (r2x),
    .gap    (gap[0]),
    .near   (near[0])
  );

  sbo_axis_gap u_gap_y (
    .center (q_data.sphere_y),
    .box    (q_data.box_y),
    .size   (q_data.extent_y),
    .r2x    (r2x),
    .gap    (gap[1]),
    .near   (near[1])
  );

  sbo_axis_gap u_gap_z (
    .center (q_data.sphere_z),
    .box    (q_data.box_z),
    .size   (q_data.extent_z),
    .r2x    (r2x),
    .gap    (gap[2]),
    .near   (near[2])
  );

  sbo_face_pick u_face (
    .q    (q_data),
    .face (face)
  );

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_gap  <= gap;
      a_near <= &near;
      a_r2x  <= r2x;
      a_face <= face;
    end
  end

  // ---- squares ----
  always_ff @(posedge clk) begin
    if (en_b) begin
      for (int k = 0; k < 3; k++) begin
        b_sq[k] <= SQ_BITS'(a_gap[k]) * SQ_BITS'(a_gap[k]);
      end
      b_rsq  <= SQ_BITS'(a_r2x) * SQ_BITS'(a_r2x);
      b_near <= a_near;
      b_face <= a_face;
    end
  end

  // ---- sum and compare; two spare sum bits keep three squares from wrapping ----
  assign sum = SUM_BITS'(b_sq[0]) + SUM_BITS'(b_sq[1]) + SUM_BITS'(b_sq[2]);
  assign hit = b_near && (sum < SUM_BITS'(b_rsq));

  always_ff @(posedge clk) begin
    if (en_out) begin
      result.hit  <= hit;
      result.face <= hit ? b_face : FACE_NONE;
    end
  end

  // ---- checks ----
  `SBO_ASSERT_SAME(a_hit_face, clk, rst, result_valid, result.hit == (result.face != FACE_NONE), "hit and face disagree")
  `SBO_ASSERT_SAME(a_ready_full, clk, rst, !query_ready, q_valid && a_valid && b_valid && result_valid && !result_ready, "query_ready low with room in pipe")
  `SBO_ASSERT_NEXT(a_zero_radius, clk, rst, b_valid && en_out && (b_rsq == '0), !result.hit, "hit reported with zero radius")
  `SBO_ASSERT_NEXT(a_accept_lands, clk, rst, query_valid && query_ready, q_valid, "accepted query not held in input register")

endmodule
